/* rtl/aggregated_topk_popularity_tracker_assert.svh */
// assertion macros for the top-k tracker
`ifndef AGGREGATED_TOPK_POPULARITY_TRACKER_ASSERT_SVH
`define AGGREGATED_TOPK_POPULARITY_TRACKER_ASSERT_SVH

// condition holds at every edge out of reset
`define ATKP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent now gives consequent in the next cycle
`define ATKP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/atkp_pkg.sv */
`default_nettype none
package atkp_pkg;
	localparam int DEF_NUM_SOURCES = 64;
	localparam int DEF_TOPK_MAX    = 8;
	localparam int DEF_VALUE_BITS  = 32;

	localparam int POS_W     = 4;
	localparam int SRC_W     = 6;
	localparam int LIMIT_W   = 4;
	localparam int SUM_OUT_W = 38;
	localparam int CNT_OUT_W = 7;
	localparam int TOPI_W    = 35;
	localparam int SIZE_W    = 32;
	localparam int POP_W     = 32;
	localparam int REQ_W     = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_DROP,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] pos;
		logic [SRC_W-1:0] src;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_APPLY,
		ST_OFFER,
		ST_INS,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

/* rtl/atkp_cell.sv */
`default_nettype none
module atkp_cell #(
	parameter int IDX = 0,
	parameter int VW  = 32
) (
	input  wire logic                    clk,
	input  wire atkp_pkg::cell_ctl_t     ctl,
	input  wire logic [VW-1:0]           new_val,
	input  wire logic [atkp_pkg::SRC_W-1:0] left_src,
	input  wire logic [VW-1:0]           left_val,
	input  wire logic [atkp_pkg::SRC_W-1:0] right_src,
	input  wire logic [VW-1:0]           right_val,
	output logic      [atkp_pkg::SRC_W-1:0] src,
	output logic      [VW-1:0]           val
);
	import atkp_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	logic [SRC_W-1:0] src_q;
	logic [VW-1:0]    val_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_DROP: begin
				if (MY_POS >= ctl.pos) begin
					src_q <= right_src;
					val_q <= right_val;
				end
			end
			CELL_INSERT: begin
				if (MY_POS > ctl.pos) begin
					src_q <= left_src;
					val_q <= left_val;
				end else if (MY_POS == ctl.pos) begin
					src_q <= ctl.src;
					val_q <= new_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign src = src_q;
	assign val = val_q;
endmodule
`default_nettype wire

/* rtl/atkp_div.sv */
`default_nettype none
module atkp_div #(
	parameter int NW = 38,
	parameter int DW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic      [NW-1:0] quotient
);
	import atkp_pkg::*;

	localparam int KW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [KW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

/* rtl/aggregated_topk_popularity_tracker.sv */
`default_nettype none
// Popularity tracker for one object with a sorted top-k list held in a row of cells.
// One request is in work at a time. The list values are summed one cell per cycle
// at the start of each request. A clear of a present source then removes its entry.
// An update may remove the source's old entry, evict the minimum and insert, in that
// order. An update or clear of a present source that is off the list first runs the
// bit-serial divider that estimates its old value. A request is also held while the
// output register is stalled. The next request is taken while the previous response
// waits at the output register.
module aggregated_topk_popularity_tracker #(
	parameter int NUM_SOURCES = atkp_pkg::DEF_NUM_SOURCES,
	parameter int TOPK_MAX    = atkp_pkg::DEF_TOPK_MAX,
	parameter int VALUE_BITS  = atkp_pkg::DEF_VALUE_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [atkp_pkg::LIMIT_W-1:0]      cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [atkp_pkg::REQ_W-1:0]        req_type,
	input  wire logic [atkp_pkg::SRC_W-1:0]        edge_index,
	input  wire logic [atkp_pkg::POP_W-1:0]        popularity,
	input  wire logic [atkp_pkg::SIZE_W-1:0]       obj_size,
	input  wire logic [atkp_pkg::LIMIT_W-1:0]      topi_count,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [atkp_pkg::SUM_OUT_W-1:0]    sum_popularity,
	output logic      [atkp_pkg::CNT_OUT_W-1:0]    present_count,
	output logic      [atkp_pkg::LIMIT_W-1:0]      topk_length,
	output logic                                   all_clear,
	output logic                                   was_cleared,
	output logic      [atkp_pkg::TOPI_W-1:0]       topi_sum,
	output logic      [63:0]                       placement_mask,
	output logic      [atkp_pkg::SIZE_W-1:0]       obj_size_out
);
	import atkp_pkg::*;
	`include "aggregated_topk_popularity_tracker_assert.svh"

	localparam int VW   = VALUE_BITS;
	localparam int SUMW = VALUE_BITS + 6;
	localparam int LW   = $clog2(TOPK_MAX + 1);
	localparam int IW   = (TOPK_MAX > 1) ? $clog2(TOPK_MAX) : 1;
	localparam int CW   = $clog2(NUM_SOURCES + 1);
	localparam int PW   = $clog2(NUM_SOURCES);

	function automatic logic [SUMW-1:0] sat_add(input logic [SUMW-1:0] a,
		input logic [SUMW-1:0] b);
		logic [SUMW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUMW] ? {SUMW{1'b1}} : s[SUMW-1:0];
	endfunction

	function automatic logic [SUMW-1:0] clamp_sub(input logic [SUMW-1:0] a,
		input logic [SUMW-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	state_t state_q, state_d;

	logic [LIMIT_W-1:0]     limit_q;
	logic [NUM_SOURCES-1:0] present_q;
	logic [CW-1:0]          count_q;
	logic [SUMW-1:0]        rs_q;
	logic [LW-1:0]          len_q;
	logic [SIZE_W-1:0]      size_q;
	logic                   out_valid_q;

	logic [REQ_W-1:0]  req_q;
	logic [SRC_W-1:0]  idx_q;
	logic [VW-1:0]     vnew_q;
	logic [SIZE_W-1:0] osz_q;
	logic [LIMIT_W-1:0] ti_q;
	logic              ok_q;
	logic [LW-1:0]     cnt_q;
	logic [SUMW-1:0]   acc_q;
	logic [63:0]       mask_q;
	logic [SUMW-1:0]   old_q;
	logic              cleared_q;

	logic [SUM_OUT_W-1:0] o_sum_q;
	logic [CNT_OUT_W-1:0] o_cnt_q;
	logic [LIMIT_W-1:0]   o_len_q;
	logic                 o_clr_q;
	logic                 o_wc_q;
	logic [TOPI_W-1:0]    o_topi_q;
	logic [63:0]          o_mask_q;
	logic [SIZE_W-1:0]    o_size_q;

	logic [SRC_W-1:0] cell_src [TOPK_MAX];
	logic [VW-1:0]    cell_val [TOPK_MAX];
	cell_ctl_t        ctl;

	logic              is_upd, is_clr, is_qry, pres, touch, fresh;
	logic              scan_end, den_zero, full, reject, out_go, scan_add;
	logic              hit_any, sorted_ok;
	logic [IW-1:0]     hit_pos;
	logic [LW-1:0]     ins_pos, lim, ti_eff, lo;
	logic [CW-1:0]     den;
	logic [IW-1:0]     rd_idx;
	logic              div_start, div_done;
	logic [SUMW-1:0]   div_quo;

	// row of list cells
	for (genvar g = 0; g < TOPK_MAX; g++) begin : g_cell
		localparam int LFT = (g == 0) ? 0 : g - 1;
		localparam int RGT = (g == TOPK_MAX - 1) ? g : g + 1;
		atkp_cell #(.IDX(g), .VW(VW)) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_val   (vnew_q),
			.left_src  (cell_src[LFT]),
			.left_val  (cell_val[LFT]),
			.right_src (cell_src[RGT]),
			.right_val (cell_val[RGT]),
			.src       (cell_src[g]),
			.val       (cell_val[g])
		);
	end

	atkp_div #(.NW(SUMW), .DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (clamp_sub(rs_q, acc_q)),
		.divisor  (den),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign is_upd   = req_q == REQ_UPDATE;
	assign is_clr   = req_q == REQ_CLEAR;
	assign is_qry   = req_q == REQ_QUERY;
	assign pres     = ok_q && present_q[idx_q[PW-1:0]];
	assign touch    = (is_upd || is_clr) && pres;
	assign fresh    = is_upd && ok_q && !pres;
	assign scan_end = cnt_q == len_q;
	assign den_zero = !(8'(count_q) > 8'(len_q));
	assign den      = CW'(8'(count_q) - 8'(len_q));
	assign rd_idx   = cnt_q[IW-1:0];

	always_comb begin
		if (limit_q == '0)
			lim = LW'(1);
		else if (8'(limit_q) > 8'(TOPK_MAX))
			lim = LW'(TOPK_MAX);
		else
			lim = LW'(limit_q);
	end

	assign full     = len_q >= lim;
	assign reject   = (len_q == '0) || (vnew_q <= cell_val[0]);
	assign ti_eff   = (8'(ti_q) > 8'(len_q)) ? len_q : LW'(ti_q);
	assign lo       = len_q - ti_eff;
	assign scan_add = !is_qry || (cnt_q >= lo);
	assign out_go   = !out_valid_q || !out_stall;

	// first matching entry and insertion point
	always_comb begin
		hit_any   = 1'b0;
		hit_pos   = '0;
		ins_pos   = len_q;
		sorted_ok = 1'b1;
		for (int p = TOPK_MAX - 1; p >= 0; p--) begin
			if (LW'(p) < len_q && cell_src[p] == idx_q) begin
				hit_any = 1'b1;
				hit_pos = IW'(p);
			end
			if (LW'(p) < len_q && cell_val[p] > vnew_q)
				ins_pos = LW'(p);
		end
		for (int p = 1; p < TOPK_MAX; p++) begin
			if (LW'(p) < len_q && cell_val[p-1] > cell_val[p])
				sorted_ok = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end) begin
					if (fresh)
						state_d = ST_OFFER;
					else if (touch)
						state_d = (hit_any || den_zero) ? ST_APPLY : ST_DIV;
					else
						state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_APPLY;
			end
			ST_APPLY: state_d = is_upd ? ST_OFFER : ST_DONE;
			ST_OFFER: state_d = (full && reject) ? ST_DONE : ST_INS;
			ST_INS:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.op    = CELL_HOLD;
		ctl.pos   = '0;
		ctl.src   = idx_q;
		in_stall  = state_q != ST_IDLE;
		div_start = (state_q == ST_SCAN) && scan_end && touch && !hit_any && !den_zero;
		unique case (state_q)
			ST_APPLY: begin
				if (hit_any) begin
					ctl.op  = CELL_DROP;
					ctl.pos = POS_W'(hit_pos);
				end
			end
			ST_OFFER: begin
				if (full && !reject)
					ctl.op = CELL_DROP;
			end
			ST_INS: begin
				if (8'(len_q) < 8'(TOPK_MAX)) begin
					ctl.op  = CELL_INSERT;
					ctl.pos = POS_W'(ins_pos);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIMIT_RESET;
			present_q   <= '0;
			count_q     <= '0;
			rs_q        <= '0;
			len_q       <= '0;
			size_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				limit_q <= cfg_wdata;
			out_valid_q <= (state_q == ST_DONE && out_go) || (out_valid_q && out_stall);
			unique case (state_q)
				ST_SCAN: begin
					if (scan_end) begin
						if (is_upd && ok_q)
							size_q <= osz_q;
						if (fresh) begin
							rs_q                       <= sat_add(rs_q, SUMW'(vnew_q));
							present_q[idx_q[PW-1:0]]   <= 1'b1;
							count_q                    <= count_q + 1'b1;
						end
					end
				end
				ST_APPLY: begin
					if (is_upd) begin
						rs_q <= clamp_sub(sat_add(rs_q, SUMW'(vnew_q)), old_q);
					end else begin
						rs_q                     <= clamp_sub(rs_q, old_q);
						present_q[idx_q[PW-1:0]] <= 1'b0;
						count_q                  <= count_q - 1'b1;
					end
					if (hit_any)
						len_q <= len_q - 1'b1;
				end
				ST_OFFER: begin
					if (full && !reject)
						len_q <= len_q - 1'b1;
				end
				ST_INS: begin
					if (8'(len_q) < 8'(TOPK_MAX))
						len_q <= len_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q     <= req_type;
				idx_q     <= edge_index;
				vnew_q    <= VW'(popularity);
				osz_q     <= obj_size;
				ti_q      <= topi_count;
				ok_q      <= 7'(edge_index) < 7'(NUM_SOURCES);
				cnt_q     <= '0;
				acc_q     <= '0;
				mask_q    <= '0;
				cleared_q <= 1'b0;
			end
			ST_SCAN: begin
				if (!scan_end) begin
					cnt_q <= cnt_q + 1'b1;
					if (scan_add)
						acc_q <= sat_add(acc_q, SUMW'(cell_val[rd_idx]));
					if (is_qry && scan_add)
						mask_q[cell_src[rd_idx]] <= 1'b1;
				end else if (touch) begin
					old_q <= hit_any ? SUMW'(cell_val[hit_pos]) : '0;
				end
			end
			ST_DIV: begin
				if (div_done)
					old_q <= div_quo;
			end
			ST_APPLY: begin
				if (is_clr)
					cleared_q <= 1'b1;
			end
			ST_DONE: begin
				if (out_go) begin
					o_sum_q  <= SUM_OUT_W'(rs_q);
					o_cnt_q  <= CNT_OUT_W'(count_q);
					o_len_q  <= LIMIT_W'(len_q);
					o_clr_q  <= count_q == '0;
					o_wc_q   <= cleared_q;
					o_topi_q <= is_qry ? TOPI_W'(acc_q) : '0;
					o_mask_q <= mask_q;
					o_size_q <= size_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign sum_popularity  = o_sum_q;
	assign present_count   = o_cnt_q;
	assign topk_length     = o_len_q;
	assign all_clear       = o_clr_q;
	assign was_cleared     = o_wc_q;
	assign topi_sum        = o_topi_q;
	assign placement_mask  = o_mask_q;
	assign obj_size_out    = o_size_q;

	`ATKP_ASSERT_ALWAYS(a_len_bound, 8'(len_q) <= 8'(TOPK_MAX), "list longer than its cells")
	`ATKP_ASSERT_ALWAYS(a_count_bits, count_q == CW'($countones(present_q)), "count off bitmap")
	`ATKP_ASSERT_ALWAYS(a_sorted, sorted_ok, "list out of ascending order")
	`ATKP_ASSERT_NEXT(a_resp_load, state_q == ST_DONE && out_go, out_valid_q, "response lost")
endmodule
`default_nettype wire

/* tb/aggregated_topk_popularity_tracker_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module aggregated_topk_popularity_tracker_tb;
	import atkp_pkg::*;

	localparam int NSRC = 64;
	localparam int KMAX = 8;
	localparam logic [37:0] SUM_SAT = {38{1'b1}};
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [37:0] sum_pop;
		logic [6:0]  cnt;
		logic [3:0]  len;
		logic        clr_all;
		logic        cleared;
		logic [34:0] tsum;
		logic [63:0] mask;
		logic [31:0] osize;
	} tracker_resp_t;

	class popularity_scoreboard;
		logic [63:0]   present;
		logic [6:0]    count;
		logic [37:0]   total;
		logic [5:0]    srcs[KMAX];
		logic [31:0]   vals[KMAX];
		int            length;
		logic [31:0]   size_q;
		int            limit;
		tracker_resp_t pending[$];
		int            errors;

		function void init();
			present = '0; count = '0; total = '0; length = 0; size_q = '0;
			limit = 8; errors = 0;
			pending.delete();
		endfunction

		function logic [37:0] sat_add(logic [37:0] a, logic [37:0] b);
			logic [38:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[38] ? SUM_SAT : s[37:0];
		endfunction

		function int find_src(logic [5:0] s);
			for (int p = 0; p < length; p++)
				if (srcs[p] == s) return p;
			return -1;
		endfunction

		function void remove_at(int pos);
			for (int p = pos; p + 1 < length; p++) begin
				srcs[p] = srcs[p + 1];
				vals[p] = vals[p + 1];
			end
			length--;
		endfunction

		function void insert_sorted(logic [5:0] s, logic [31:0] v);
			int cap, pos;
			cap = (limit < 1) ? 1 : (limit > KMAX ? KMAX : limit);
			if (length >= cap) begin
				if (length == 0 || v <= vals[0]) return;
				remove_at(0);
			end
			if (length >= KMAX) return;
			pos = 0;
			while (pos < length && !(v < vals[pos])) pos++;
			for (int p = length; p > pos; p--) begin
				srcs[p] = srcs[p - 1];
				vals[p] = vals[p - 1];
			end
			srcs[pos] = s;
			vals[pos] = v;
			length++;
		endfunction

		function logic [37:0] old_value(logic [5:0] s);
			int at;
			logic [37:0] lsum, rem;
			logic [6:0] den;
			at = find_src(s);
			if (at >= 0) return {6'b0, vals[at]};
			lsum = '0;
			for (int p = 0; p < length; p++) lsum += {6'b0, vals[p]};
			den = (count > length) ? count - 7'(length) : '0;
			if (den == 0) return '0;
			rem = (total > lsum) ? total - lsum : '0;
			return rem / den;
		endfunction

		function void note_request(logic [1:0] rt, logic [5:0] ix, logic [31:0] pop,
				logic [31:0] osz, logic [3:0] ti);
			tracker_resp_t r;
			logic [37:0] old;
			int at, n;
			r.cleared = 1'b0; r.tsum = '0; r.mask = '0;
			if (rt == REQ_UPDATE) begin
				if (!present[ix]) begin
					total = sat_add(total, {6'b0, pop});
					insert_sorted(ix, pop);
					present[ix] = 1'b1;
					count++;
				end else begin
					old = old_value(ix);
					total = sat_add(total, {6'b0, pop});
					total = (total > old) ? total - old : '0;
					at = find_src(ix);
					if (at >= 0) remove_at(at);
					insert_sorted(ix, pop);
				end
				size_q = osz;
			end else if (rt == REQ_CLEAR) begin
				if (present[ix]) begin
					old = old_value(ix);
					total = (total > old) ? total - old : '0;
					at = find_src(ix);
					if (at >= 0) remove_at(at);
					present[ix] = 1'b0;
					if (count > 0) count--;
					r.cleared = 1'b1;
				end
			end else if (rt == REQ_QUERY) begin
				logic [37:0] acc;
				acc = '0;
				n = (int'(ti) > length) ? length : int'(ti);
				for (int p = length - n; p < length; p++) begin
					acc = sat_add(acc, {6'b0, vals[p]});
					r.mask[srcs[p]] = 1'b1;
				end
				r.tsum = acc[34:0];
			end
			r.sum_pop = total; r.cnt = count; r.len = 4'(length);
			r.clr_all = (count == 0); r.osize = size_q;
			pending.push_back(r);
		endfunction

		function void check_response(tracker_resp_t a);
			tracker_resp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response sum %0d", a.sum_pop);
				return;
			end
			e = pending[0];
			pending.delete(0);
			if (e !== a) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp %p act %p", e, a);
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
	logic [3:0] cfg_wdata, topi_count, topk_length;
	logic [1:0] req_type;
	logic [5:0] edge_index;
	logic [31:0] popularity, obj_size, obj_size_out;
	logic [37:0] sum_popularity;
	logic [6:0] present_count;
	logic all_clear, was_cleared;
	logic [34:0] topi_sum;
	logic [63:0] placement_mask;

	popularity_scoreboard sb;
	bit calm, hold_long;

	aggregated_topk_popularity_tracker u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.edge_index(edge_index), .popularity(popularity), .obj_size(obj_size),
		.topi_count(topi_count), .out_valid(out_valid), .out_stall(out_stall),
		.sum_popularity(sum_popularity), .present_count(present_count),
		.topk_length(topk_length), .all_clear(all_clear), .was_cleared(was_cleared),
		.topi_sum(topi_sum), .placement_mask(placement_mask),
		.obj_size_out(obj_size_out)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// receiver side
	always @(posedge clk) begin
		tracker_resp_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.sum_pop = sum_popularity; r.cnt = present_count; r.len = topk_length;
			r.clr_all = all_clear; r.cleared = was_cleared; r.tsum = topi_sum;
			r.mask = placement_mask; r.osize = obj_size_out;
			sb.check_response(r);
		end
		out_stall <= hold_long || (!calm && $urandom_range(99) < 7);
	end

	task automatic send_request(logic [1:0] rt, logic [5:0] ix, logic [31:0] pop,
			logic [31:0] osz, logic [3:0] ti);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		req_type <= rt; edge_index <= ix; popularity <= pop;
		obj_size <= osz; topi_count <= ti;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(rt, ix, pop, osz, ti);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_limit(logic [3:0] v);
		drain();
		cfg_we <= 1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.limit = int'(v);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'hFFFF_FFFF;
			1: return '0;
			2: return 32'($urandom_range(4)) << 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int n, int span);
		logic [1:0] rt;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			rt = (k < 55) ? REQ_UPDATE : (k < 78) ? REQ_CLEAR : (k < 97) ? REQ_QUERY :
				REQ_UNKNOWN;
			send_request(rt, 6'($urandom_range(span - 1)), rand_value(), $urandom,
				4'($urandom_range(15)));
		end
	endtask

	initial begin
		sb = new();
		sb.init();
		arst_n = 0; cfg_we = 0; cfg_wdata = '0; in_valid = 0; out_stall = 0;
		req_type = '0; edge_index = '0; popularity = '0; obj_size = '0;
		topi_count = '0; calm = 0; hold_long = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send_request(REQ_QUERY, '0, '0, '0, 4'd8);
		send_request(REQ_CLEAR, 6'd5, '0, '0, '0);
		send_request(REQ_UPDATE, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		send_request(REQ_UPDATE, 6'd63, 32'hFFFF_FFFF, '0, '0);
		for (int i = 1; i <= 9; i++)
			send_request(REQ_UPDATE, 6'(i), 32'(i) << 16, 32'(i), 4'd15);
		send_request(REQ_UPDATE, 6'd10, 32'h0001_0000, 32'h5555_AAAA, '0);
		send_request(REQ_UPDATE, 6'd1, 32'h0002_0000, '0, '0);
		send_request(REQ_UPDATE, 6'd63, 32'h0000_0001, '0, '0);
		send_request(REQ_QUERY, '0, '0, '0, 4'd8);
		send_request(REQ_QUERY, '0, '0, '0, 4'd15);
		send_request(REQ_QUERY, '0, '0, '0, 4'd3);
		send_request(REQ_CLEAR, 6'd2, '0, '0, '0);
		send_request(REQ_CLEAR, 6'd63, '0, '0, '0);
		send_request(REQ_UNKNOWN, 6'd7, 32'hAAAA_5555, 32'h1234_5678, 4'd2);
		send_request(REQ_UPDATE, 6'd40, 32'h8000_0000, 32'hAAAA_5555, 4'd0);

		set_limit(4'd3);
		random_phase(200, 12);
		set_limit(4'd1);
		random_phase(150, 8);
		set_limit(4'd0);
		random_phase(100, 8);
		set_limit(4'd15);
		random_phase(150, 64);

		// long receiver hold while requests keep coming
		fork
			begin
				hold_long = 1;
				repeat (400) @(posedge clk);
				hold_long = 0;
			end
			random_phase(40, 16);
		join
		drain();

		set_limit(4'd8);
		calm = 1;
		random_phase(300, 20);
		calm = 0;
		set_limit(4'd5);
		random_phase(400, 16);
		set_limit(4'd8);
		random_phase(400, 64);
		set_limit(4'd2);
		random_phase(100, 64);

		for (int i = 0; i < NSRC; i++) send_request(REQ_CLEAR, 6'(i), '0, '0, '0);
		in_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
